FILE: src/rdfs_pkg.sv
// shared types and codes for the depth-first path search block
// no dependencies
package rdfs_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] from_node;
        logic [5:0] to_node;
    } in_item_t;

    typedef struct packed {
        logic [5:0] path_node;
        logic       last;
        logic       found;
        logic       status;
        logic [9:0] edge_count;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input transaction
        logic clr_graph;
        logic add_edge;
        logic srch_init; // clear marks, push start
        logic read_top;  // issue memory read of top's current child
        logic step;      // act on registered child data
        logic pop;       // drop top, read the entry below it
        logic pop_load;  // make the entry below the new top
        logic cnt_load;  // take the fetched child count of the top
        logic emit_path; // load output with the next path entry
        logic emit_stat; // load output with a single status result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_clear;
        logic op_add;
        logic op_search;
        logic srch_bad;  // start or goal out of range
        logic at_goal;
        logic stack_empty;
        logic need_read; // top has an unchecked child
        logic push_ok;   // registered child gets pushed
        logic emit_done; // next path entry is the last one
    } dp_stat_t;

endpackage

FILE: src/rdfs_datapath.sv
// datapath: child table memory, counts, marks, path stack and output register
// depends on rdfs_pkg
module rdfs_datapath #(
    parameter int NODES  = 64,
    parameter int DEGREE = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rdfs_pkg::in_item_t  in_item,
    input  rdfs_pkg::dp_cmd_t   cmd,
    output rdfs_pkg::dp_stat_t  stat,
    output rdfs_pkg::out_item_t out_item
);
    import rdfs_pkg::*;

    localparam int LIVE = (NODES < 64) ? NODES : 64;
    localparam int CW   = $clog2(DEGREE + 1);
    localparam int NW   = (LIVE > 1) ? $clog2(LIVE) : 1;
    localparam int SW   = $clog2(LIVE + 1);
    localparam int MD   = LIVE * DEGREE;
    localparam int AW   = (MD > 1) ? $clog2(MD) : 1;

    logic [5:0]      tbl_mem [MD];
    logic [CW-1:0]   cnt_mem [LIVE];
    logic [5:0]      stk_mem [LIVE];
    logic [CW-1:0]   sidx_mem [LIVE];
    logic [LIVE-1:0] cnt_vld_reg;
    logic [LIVE-1:0] vis_reg;
    logic [SW-1:0]   depth_reg;
    logic [9:0]      edges_reg;
    in_item_t        item_reg;
    logic [5:0]      top_reg;
    logic [CW-1:0]   top_idx_reg;
    logic [CW-1:0]   top_cnt_reg;
    logic [5:0]      child_reg;
    logic [SW-1:0]   emit_reg;
    logic [5:0]      stk_rd_reg;
    logic [CW-1:0]   sidx_rd_reg;
    logic [CW-1:0]   cnt_rd_reg;
    logic            cnt_vld_rd_reg;

    logic from_ok, to_ok, add_ok, child_ok, push_ok, status_w;
    logic [NW-1:0] from_i, top_i, child_i, depth_i, cnt_raddr, stk_raddr;
    logic [CW-1:0] cnt_eff;
    logic [AW-1:0] wr_addr, rd_addr;

    assign from_ok   = {26'd0, item_reg.from_node} < LIVE;
    assign to_ok     = {26'd0, item_reg.to_node} < LIVE;
    assign from_i    = item_reg.from_node[NW-1:0];
    assign top_i     = top_reg[NW-1:0];
    assign child_i   = child_reg[NW-1:0];
    assign depth_i   = depth_reg[NW-1:0];
    assign cnt_eff   = cnt_vld_rd_reg ? cnt_rd_reg : '0;
    assign add_ok    = from_ok && to_ok && ({{(32-CW){1'b0}}, cnt_eff} < DEGREE);
    assign wr_addr   = AW'(int'(from_i) * DEGREE + int'(cnt_eff));
    assign rd_addr   = AW'(int'(top_i) * DEGREE + int'(top_idx_reg));
    assign child_ok  = ({26'd0, child_reg} < LIVE) && !vis_reg[child_i];
    assign push_ok   = child_ok && (depth_reg < SW'(LIVE));
    assign cnt_raddr = cmd.pop_load ? stk_rd_reg[NW-1:0] : (cmd.step ? child_i : from_i);
    assign status_w  = (item_reg.operation == OP_ADD) && !add_ok;

    always_comb
    begin
        if (cmd.pop)
        begin
            stk_raddr = (depth_reg >= SW'(2)) ? NW'(depth_reg - SW'(2)) : '0;
        end
        else if (cmd.emit_path)
        begin
            stk_raddr = NW'(emit_reg + SW'(1));
        end
        else
        begin
            stk_raddr = NW'(emit_reg);
        end
    end

    assign stat.op_clear    = item_reg.operation == OP_CLEAR;
    assign stat.op_add      = item_reg.operation == OP_ADD;
    assign stat.op_search   = item_reg.operation == OP_SEARCH;
    assign stat.srch_bad    = !from_ok || !to_ok;
    assign stat.at_goal     = top_reg == item_reg.to_node;
    assign stat.stack_empty = depth_reg == '0;
    assign stat.need_read   = top_idx_reg < top_cnt_reg;
    assign stat.push_ok     = push_ok;
    assign stat.emit_done   = (emit_reg + SW'(1)) == depth_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        if (cmd.add_edge && add_ok)
        begin
            tbl_mem[wr_addr] <= item_reg.to_node;
            cnt_mem[from_i]  <= cnt_eff + 1'b1;
        end
        if (cmd.read_top)
        begin
            child_reg <= tbl_mem[rd_addr];
        end
        cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    // stack memories: one write and one read port each
    always_ff @(posedge clk)
    begin
        if (cmd.srch_init)
        begin
            stk_mem[0] <= item_reg.from_node;
        end
        else if (cmd.step && push_ok)
        begin
            stk_mem[depth_i]                  <= child_reg;
            sidx_mem[NW'(depth_reg - SW'(1))] <= top_idx_reg;
        end
        stk_rd_reg  <= stk_mem[stk_raddr];
        sidx_rd_reg <= sidx_mem[stk_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg    <= '0;
            cnt_vld_rd_reg <= 1'b0;
            vis_reg        <= '0;
            depth_reg      <= '0;
            edges_reg      <= '0;
            top_reg        <= '0;
            top_idx_reg    <= '0;
            top_cnt_reg    <= '0;
            emit_reg       <= '0;
        end
        else
        begin
            cnt_vld_rd_reg <= cnt_vld_reg[cnt_raddr];
            if (cmd.clr_graph)
            begin
                cnt_vld_reg <= '0;
                edges_reg   <= '0;
            end
            if (cmd.add_edge && add_ok)
            begin
                cnt_vld_reg[from_i] <= 1'b1;
                if (edges_reg != 10'd1023)
                begin
                    edges_reg <= edges_reg + 1'b1;
                end
            end
            if (cmd.srch_init)
            begin
                vis_reg     <= (from_ok && to_ok) ? ({{(LIVE-1){1'b0}}, 1'b1} << from_i) : '0;
                depth_reg   <= (from_ok && to_ok) ? SW'(1) : '0;
                top_reg     <= item_reg.from_node;
                top_idx_reg <= '0;
                emit_reg    <= '0;
            end
            if (cmd.read_top)
            begin
                top_idx_reg <= top_idx_reg + 1'b1;
            end
            if (cmd.step && child_ok)
            begin
                vis_reg[child_i] <= 1'b1;
                if (push_ok)
                begin
                    depth_reg   <= depth_reg + 1'b1;
                    top_reg     <= child_reg;
                    top_idx_reg <= '0;
                end
            end
            if (cmd.pop)
            begin
                depth_reg <= depth_reg - 1'b1;
            end
            if (cmd.pop_load)
            begin
                top_reg     <= stk_rd_reg;
                top_idx_reg <= sidx_rd_reg;
            end
            if (cmd.cnt_load)
            begin
                top_cnt_reg <= cnt_eff;
            end
            if (cmd.emit_path)
            begin
                emit_reg <= emit_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_path)
        begin
            out_item.path_node  <= stk_rd_reg;
            out_item.last       <= stat.emit_done;
            out_item.found      <= 1'b1;
            out_item.status     <= 1'b0;
            out_item.edge_count <= edges_reg;
        end
        else if (cmd.emit_stat)
        begin
            out_item.path_node  <= '0;
            out_item.last       <= 1'b1;
            out_item.found      <= 1'b0;
            out_item.status     <= status_w;
            out_item.edge_count <= cmd.clr_graph ? 10'd0
                                   : (cmd.add_edge && add_ok && edges_reg != 10'd1023)
                                   ? edges_reg + 1'b1 : edges_reg;
        end
    end
endmodule

FILE: src/rdfs_ctrl.sv
// controller state machine for the depth-first path search block
// depends on rdfs_pkg
module rdfs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  rdfs_pkg::dp_stat_t stat,
    output rdfs_pkg::dp_cmd_t  cmd
);
    import rdfs_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DEC  = 9'b000000010,
        S_ADD  = 9'b000000100,
        S_CNT  = 9'b000001000,
        S_TOP  = 9'b000010000,
        S_RD   = 9'b000100000,
        S_POP  = 9'b001000000,
        S_PATH = 9'b010000000,
        S_MISS = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   out_free;

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = ov_reg;
    assign out_free  = !ov_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.op_add)
                begin
                    state_next = S_ADD;
                end
                else if (stat.op_search && !stat.srch_bad)
                begin
                    cmd.srch_init = 1'b1;
                    state_next    = S_CNT;
                end
                else if (out_free)
                begin
                    cmd.clr_graph = stat.op_clear;
                    cmd.srch_init = stat.op_search;
                    cmd.emit_stat = 1'b1;
                    ov_next       = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ADD:
            begin
                if (out_free)
                begin
                    cmd.add_edge  = 1'b1;
                    cmd.emit_stat = 1'b1;
                    ov_next       = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_CNT:
            begin
                cmd.cnt_load = 1'b1;
                state_next   = S_TOP;
            end
            S_TOP:
            begin
                if (stat.stack_empty)
                begin
                    state_next = S_MISS;
                end
                else if (stat.at_goal)
                begin
                    state_next = S_PATH;
                end
                else if (stat.need_read)
                begin
                    cmd.read_top = 1'b1;
                    state_next   = S_RD;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POP;
                end
            end
            S_RD:
            begin
                cmd.step   = 1'b1;
                state_next = stat.push_ok ? S_CNT : S_TOP;
            end
            S_POP:
            begin
                cmd.pop_load = 1'b1;
                state_next   = S_CNT;
            end
            S_PATH:
            begin
                if (out_free)
                begin
                    cmd.emit_path = 1'b1;
                    ov_next       = 1'b1;
                    state_next    = stat.emit_done ? S_IDLE : S_PATH;
                end
            end
            S_MISS:
            begin
                if (out_free)
                begin
                    cmd.emit_stat = 1'b1;
                    ov_next       = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

FILE: src/roadmap_dfs_path_search_core.sv
// Directed-graph store with depth-first path search. One transaction at a time:
// clear and unused codes are decoded and answered with a status item, and add-edge
// items pass through an add state first. A search fetches the start node's child
// count, then walks the child tables (at most NODES*DEGREE reads, one memory read
// port), pushing and backtracking, then emits one path node per item at the goal.
// A stalled result holds the controller until it is taken.
// depends on rdfs_pkg, rdfs_ctrl, rdfs_datapath
module roadmap_dfs_path_search_core #(
    parameter int NODES  = 64,
    parameter int DEGREE = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rdfs_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rdfs_pkg::out_item_t out_data
);
    import rdfs_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rdfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rdfs_datapath #(
        .NODES  (NODES),
        .DEGREE (DEGREE)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (out_data)
    );
endmodule
